### rtl/tun_pkg.sv
// shared constants for the triangle unit normal pipeline
// no dependencies
package tun_pkg;
  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 14;
  localparam int NORM_BITS      = 16;
  localparam int MAG_BITS       = 34;
endpackage

### rtl/tun_if.sv
// valid/ready channels of the triangle unit normal block
// depends on tun_pkg
interface tun_in_if #(parameter int COORD_BITS = tun_pkg::COORD_BITS_DEF);
  logic valid;
  logic ready;
  logic signed [COORD_BITS-1:0] a_x, a_y, a_z;
  logic signed [COORD_BITS-1:0] b_x, b_y, b_z;
  logic signed [COORD_BITS-1:0] c_x, c_y, c_z;
  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, input ready);
  modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, output ready);
endinterface

interface tun_out_if;
  logic valid;
  logic ready;
  logic signed [tun_pkg::NORM_BITS-1:0] normal_x, normal_y, normal_z;
  logic [tun_pkg::MAG_BITS-1:0] magnitude;
  logic degenerate;
  modport source (output valid, normal_x, normal_y, normal_z, magnitude, degenerate,
                  input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, magnitude, degenerate,
                output ready);
endinterface

### rtl/tun_cross.sv
// edge vectors, cross product and sum of squares, seven stages
// depends on tun_pkg
module tun_cross #(
  parameter int COORD_BITS = tun_pkg::COORD_BITS_DEF,
  parameter int AW = 2 * COORD_BITS + 3,
  parameter int SW = 2 * AW + 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic vld_i,
  input  logic signed [COORD_BITS-1:0] a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
  output logic vld_o,
  output logic [AW-1:0] abs_o [3],
  output logic [2:0] neg_o,
  output logic [SW-1:0] sum_o
);
  import tun_pkg::*;

  localparam int DW  = COORD_BITS + 1;
  localparam int PW  = 2 * DW;
  localparam int HW  = (AW + 1) / 2;
  localparam int HIW = AW - HW;

  logic [6:0] vld_r;
  logic signed [DW-1:0] ux_r, uy_r, uz_r, vx_r, vy_r, vz_r;
  logic signed [PW-1:0] p_yz_r, p_zy_r, p_zx_r, p_xz_r, p_xy_r, p_yx_r;
  logic signed [AW-1:0] n_r [3];
  logic [AW-1:0] abs4_r [3], abs5_r [3], abs6_r [3], abs7_r [3];
  logic [2:0] neg4_r, neg5_r, neg6_r, neg7_r;
  logic [2*HIW-1:0] hh_r [3];
  logic [HIW+HW-1:0] hl_r [3];
  logic [2*HW-1:0] ll_r [3];
  logic [SW-1:0] sq_r [3];
  logic [SW-1:0] sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[5:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ux_r <= DW'(a_x) - DW'(b_x);
      uy_r <= DW'(a_y) - DW'(b_y);
      uz_r <= DW'(a_z) - DW'(b_z);
      vx_r <= DW'(a_x) - DW'(c_x);
      vy_r <= DW'(a_y) - DW'(c_y);
      vz_r <= DW'(a_z) - DW'(c_z);
      p_yz_r <= uy_r * vz_r;
      p_zy_r <= uz_r * vy_r;
      p_zx_r <= uz_r * vx_r;
      p_xz_r <= ux_r * vz_r;
      p_xy_r <= ux_r * vy_r;
      p_yx_r <= uy_r * vx_r;
      n_r[0] <= AW'(p_yz_r) - AW'(p_zy_r);
      n_r[1] <= AW'(p_zx_r) - AW'(p_xz_r);
      n_r[2] <= AW'(p_xy_r) - AW'(p_yx_r);
      neg5_r <= neg4_r;
      neg6_r <= neg5_r;
      neg7_r <= neg6_r;
      sum_r  <= sq_r[0] + sq_r[1] + sq_r[2];
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_comp
    always_ff @(posedge clk) begin
      if (en) begin
        neg4_r[k] <= n_r[k][AW-1];
        abs4_r[k] <= n_r[k][AW-1] ? AW'(-n_r[k]) : AW'(n_r[k]);
        hh_r[k]   <= abs4_r[k][AW-1:HW] * abs4_r[k][AW-1:HW];
        hl_r[k]   <= abs4_r[k][AW-1:HW] * abs4_r[k][HW-1:0];
        ll_r[k]   <= abs4_r[k][HW-1:0] * abs4_r[k][HW-1:0];
        abs5_r[k] <= abs4_r[k];
        sq_r[k]   <= (SW'(hh_r[k]) << (2 * HW)) + (SW'(hl_r[k]) << (HW + 1))
                     + SW'(ll_r[k]);
        abs6_r[k] <= abs5_r[k];
        abs7_r[k] <= abs6_r[k];
      end
    end
  end

  assign vld_o  = vld_r[6];
  assign abs_o  = abs7_r;
  assign neg_o  = neg7_r;
  assign sum_o  = sum_r;
endmodule

### rtl/tun_sqrt.sv
// integer square root, one result bit per pipeline stage
// depends on tun_pkg
module tun_sqrt #(
  parameter int SW = 72,
  parameter int RW = 36,
  parameter int SIDE_W = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic vld_i,
  input  logic [SW-1:0] sum_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic vld_o,
  output logic [RW-1:0] root_o,
  output logic [SIDE_W-1:0] side_o
);
  import tun_pkg::*;

  localparam int XW = SW + 2;

  logic [RW-1:0] vld_r;
  logic [SW-1:0] rem_r [RW];
  logic [RW-1:0] root_r [RW];
  logic [SIDE_W-1:0] side_r [RW];

  for (genvar i = 0; i < RW; i++) begin : g_bit
    localparam int B = RW - 1 - i;
    logic [SW-1:0] rem_in;
    logic [RW-1:0] root_in;
    logic [SIDE_W-1:0] side_in;
    logic vld_in;
    logic [XW-1:0] trial;
    if (i == 0) begin : g_first
      assign rem_in  = sum_i;
      assign root_in = '0;
      assign side_in = side_i;
      assign vld_in  = vld_i;
    end else begin : g_next
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign side_in = side_r[i-1];
      assign vld_in  = vld_r[i-1];
    end
    // (r + 2^b)^2 - r^2
    assign trial = (XW'(root_in) << (B + 1)) + (XW'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[i] <= side_in;
        if (XW'(rem_in) >= trial) begin
          rem_r[i]  <= SW'(XW'(rem_in) - trial);
          root_r[i] <= root_in | (RW'(1) << B);
        end else begin
          rem_r[i]  <= rem_in;
          root_r[i] <= root_in;
        end
      end
    end
  end

  assign vld_o  = vld_r[RW-1];
  assign root_o = root_r[RW-1];
  assign side_o = side_r[RW-1];
endmodule

### rtl/tun_div.sv
// three lanes of restoring fraction division, one quotient bit per stage
// depends on tun_pkg
module tun_div #(
  parameter int AW = 35,
  parameter int RW = 36,
  parameter int FRAC_BITS = tun_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic vld_i,
  input  logic [AW-1:0] num_i [3],
  input  logic [2:0] neg_i,
  input  logic [RW-1:0] den_i,
  output logic vld_o,
  output logic [FRAC_BITS:0] quo_o [3],
  output logic [2:0] neg_o,
  output logic [RW-1:0] den_o
);
  import tun_pkg::*;

  localparam int NS = FRAC_BITS + 1;
  localparam int QW = FRAC_BITS + 1;
  localparam int RMW = RW + 1;

  logic [NS-1:0] vld_r;
  logic [RW-1:0] den_r [NS];
  logic [2:0] neg_r [NS];
  logic [RMW-1:0] rem_r [NS][3];
  logic [QW-1:0] quo_r [NS][3];

  for (genvar i = 0; i < NS; i++) begin : g_stage
    logic vld_in;
    logic [RW-1:0] den_in;
    logic [2:0] neg_in;
    if (i == 0) begin : g_first
      assign vld_in = vld_i;
      assign den_in = den_i;
      assign neg_in = neg_i;
    end else begin : g_next
      assign vld_in = vld_r[i-1];
      assign den_in = den_r[i-1];
      assign neg_in = neg_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[i] <= den_in;
        neg_r[i] <= neg_in;
      end
    end

    for (genvar k = 0; k < 3; k++) begin : g_lane
      logic [RMW-1:0] rem_in;
      logic [QW-1:0] quo_in;
      if (i == 0) begin : g_first
        assign rem_in = RMW'(num_i[k]);
        assign quo_in = '0;
      end else begin : g_next
        assign rem_in = rem_r[i-1][k] << 1;
        assign quo_in = quo_r[i-1][k] << 1;
      end
      always_ff @(posedge clk) begin
        if (en) begin
          if (rem_in >= RMW'(den_in)) begin
            rem_r[i][k] <= rem_in - RMW'(den_in);
            quo_r[i][k] <= quo_in | QW'(1);
          end else begin
            rem_r[i][k] <= rem_in;
            quo_r[i][k] <= quo_in;
          end
        end
      end
    end
  end

  assign vld_o = vld_r[NS-1];
  assign quo_o = quo_r[NS-1];
  assign neg_o = neg_r[NS-1];
  assign den_o = den_r[NS-1];
endmodule

### rtl/triangle_unit_normal_top.sv
// Triangle unit normal: takes three points per word, forms the cross product
// of (A-B) and (A-C) and returns its floor length and the unit normal in fixed point
// (FRAC_BITS fraction bits, truncated toward zero). A zero cross product sets
// degenerate and gives a zero normal and zero magnitude. One word is accepted
// every clock unless the output register is full and not taken. The pipeline has
// 59 register stages at the defaults, mostly in the bit-per-stage square root
// (RW = 2*COORD_BITS + 4) and the bit-per-stage divider; it advances as a whole and
// holds on a full, untaken output register; it keeps no state between words.
// depends on tun_pkg, tun_if, tun_cross, tun_sqrt, tun_div
module triangle_unit_normal_top #(
  parameter int COORD_BITS = tun_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = tun_pkg::FRAC_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  tun_in_if.sink    in_ch,
  tun_out_if.source out_ch
);
  import tun_pkg::*;

  // magnitude of a cross component and width of the sum of squares
  localparam int AW = 2 * COORD_BITS + 3;
  localparam int SW = 2 * AW + 2;
  // root of a sum below 2^SW
  localparam int RW = AW + 1;
  localparam int SIDE_W = 3 * AW + 3;

  // whole pipeline moves when the output register can take a word
  logic en;
  logic out_vld_r;

  // cross product stage group
  logic cr_vld;
  logic [AW-1:0] cr_abs [3];
  logic [2:0] cr_neg;
  logic [SW-1:0] cr_sum;

  // square root stage group, components ride along as side data
  logic [SIDE_W-1:0] sq_side_in, sq_side_out;
  logic sq_vld;
  logic [RW-1:0] sq_root;
  logic [AW-1:0] sq_abs [3];
  logic [2:0] sq_neg;

  // divider stage group
  logic dv_vld;
  logic [FRAC_BITS:0] dv_quo [3];
  logic [2:0] dv_neg;
  logic [RW-1:0] dv_den;

  // output register
  logic signed [NORM_BITS-1:0] nrm_r [3];
  logic [MAG_BITS-1:0] mag_r;
  logic degen_r;

  assign en = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  tun_cross #(.COORD_BITS(COORD_BITS), .AW(AW), .SW(SW)) u_cross (
    .clk, .rst_n, .en,
    .vld_i (in_ch.valid),
    .a_x (in_ch.a_x), .a_y (in_ch.a_y), .a_z (in_ch.a_z),
    .b_x (in_ch.b_x), .b_y (in_ch.b_y), .b_z (in_ch.b_z),
    .c_x (in_ch.c_x), .c_y (in_ch.c_y), .c_z (in_ch.c_z),
    .vld_o (cr_vld), .abs_o (cr_abs), .neg_o (cr_neg), .sum_o (cr_sum)
  );

  assign sq_side_in = {cr_neg, cr_abs[2], cr_abs[1], cr_abs[0]};

  tun_sqrt #(.SW(SW), .RW(RW), .SIDE_W(SIDE_W)) u_sqrt (
    .clk, .rst_n, .en,
    .vld_i (cr_vld), .sum_i (cr_sum), .side_i (sq_side_in),
    .vld_o (sq_vld), .root_o (sq_root), .side_o (sq_side_out)
  );

  assign sq_abs[0] = sq_side_out[AW-1:0];
  assign sq_abs[1] = sq_side_out[2*AW-1:AW];
  assign sq_abs[2] = sq_side_out[3*AW-1:2*AW];
  assign sq_neg    = sq_side_out[SIDE_W-1:3*AW];

  tun_div #(.AW(AW), .RW(RW), .FRAC_BITS(FRAC_BITS)) u_div (
    .clk, .rst_n, .en,
    .vld_i (sq_vld), .num_i (sq_abs), .neg_i (sq_neg), .den_i (sq_root),
    .vld_o (dv_vld), .quo_o (dv_quo), .neg_o (dv_neg), .den_o (dv_den)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= dv_vld;
    end
  end

  // apply signs, zero the normal when the length is zero
  for (genvar k = 0; k < 3; k++) begin : g_out
    always_ff @(posedge clk) begin
      if (en) begin
        if (dv_den == '0) begin
          nrm_r[k] <= '0;
        end else if (dv_neg[k]) begin
          nrm_r[k] <= -NORM_BITS'(dv_quo[k]);
        end else begin
          nrm_r[k] <= NORM_BITS'(dv_quo[k]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r   <= MAG_BITS'(dv_den);
      degen_r <= (dv_den == '0);
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.normal_x   = nrm_r[0];
  assign out_ch.normal_y   = nrm_r[1];
  assign out_ch.normal_z   = nrm_r[2];
  assign out_ch.magnitude  = mag_r;
  assign out_ch.degenerate = degen_r;

  // a degenerate word carries a zero normal and zero length
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.degenerate |->
      out_ch.normal_x == '0 && out_ch.normal_y == '0 && out_ch.normal_z == '0 &&
      out_ch.magnitude == '0)
    else $error("degenerate word with nonzero normal or length");

  // the input side is only held off by a full, stalled output register
  a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid && !out_ch.ready)
    else $error("input stalled without output backpressure");

  // a stalled result word keeps its valid, magnitude and normal_x
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=>
      out_ch.valid && $stable(out_ch.magnitude) && $stable(out_ch.normal_x))
    else $error("stalled result word changed");
endmodule
